@@ sv/mass_window_ion_chromatogram_macros.svh @@
// ----------------------------------------------------------------------------
// Mass window ion chromatogram: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef MASS_WINDOW_ION_CHROMATOGRAM_MACROS_SVH
`define MASS_WINDOW_ION_CHROMATOGRAM_MACROS_SVH

// cond holds -> prop holds in the same cycle
`define MWIC_ASSERT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// cond holds -> prop holds in the next cycle
`define MWIC_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ sv/mwic_pkg.sv @@
// ----------------------------------------------------------------------------
// Mass window ion chromatogram: package
// Field widths, codes and the queue entry type shared by all modules.
// ----------------------------------------------------------------------------
package mwic_pkg;

  localparam int ACTION_W     = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int MZ_W         = 29;
  localparam int INT_W        = 32;
  localparam int SCAN_W       = 24;
  localparam int BASE_W       = 32;
  localparam int SUM_W        = 48;
  localparam int PPM_W        = 17;
  localparam int COUNT_W      = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 17;
  localparam int WIN_W        = 32;
  localparam int PROD_W       = MZ_W + PPM_W;
  localparam int PPM_SCALE    = 100000000;  // 1e-5 m/z units times 0.01 ppm
  localparam int TOL_W        = 20;         // max product / PPM_SCALE fits here

  // PPM_SCALE = 2^SCALE_SHIFT * SCALE_ODD; the odd part is divided by a
  // reciprocal multiply, split into four 19x20 partial products
  localparam int SCALE_SHIFT  = 8;
  localparam int SCALE_ODD    = 390625;
  localparam int QN_W         = PROD_W - SCALE_SHIFT;
  localparam int HALF_W       = QN_W / 2;
  localparam int RECIP_SHIFT  = QN_W + $clog2(SCALE_ODD);
  localparam int RLO_W        = 20;
  localparam int RHI_W        = 19;
  localparam int RECIP_W      = RLO_W + RHI_W;
  localparam int ACC_W        = RECIP_SHIFT + TOL_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
      ((64'd1 << RECIP_SHIFT) + 64'(SCALE_ODD) - 64'd1) / 64'(SCALE_ODD));
  localparam logic [RLO_W-1:0] RECIP_LO = RECIP[RLO_W-1:0];
  localparam logic [RLO_W-1:0] RECIP_HI = RLO_W'(RECIP >> RLO_W);
  localparam int DIV_STEPS    = 4;
  localparam int STEP_W       = $clog2(DIV_STEPS);

  localparam int MAX_OUT      = 16;
  localparam int OUT_CNT_W    = $clog2(MAX_OUT + 1);
  localparam int QUEUE_DEPTH  = 4;

  localparam int SLOTS_DEFAULT          = 16;
  localparam int INTENSITY_BITS_DEFAULT = 32;

  localparam logic [PPM_W-1:0]   PPM_RESET   = PPM_W'(1000);
  localparam logic [COUNT_W-1:0] COUNT_RESET = '0;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PEAK = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SCAN = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PPM_TOLERANCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRECURSOR_COUNT = 1'd1;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_PEAK,
    KIND_SCAN
  } mwic_kind_e;

  // queue entry; lo carries the peak m/z for peak requests
  typedef struct packed {
    mwic_kind_e              kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [WIN_W-1:0]        lo;
    logic [WIN_W-1:0]        hi;
    logic [INT_W-1:0]        intensity;
    logic [SCAN_W-1:0]       scan;
  } mwic_op_t;

endpackage

@@ sv/mwic_if.sv @@
// ----------------------------------------------------------------------------
// Mass window ion chromatogram: channel interfaces
// Request, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mwic_req_if;
  logic                              valid;
  logic                              ready;
  logic [mwic_pkg::ACTION_W-1:0]     action;
  logic [mwic_pkg::SLOT_FIELD_W-1:0] slot;
  logic [mwic_pkg::MZ_W-1:0]         mz_value;
  logic [mwic_pkg::INT_W-1:0]        intensity;
  logic [mwic_pkg::SCAN_W-1:0]       scan_id;

  modport source (output valid, action, slot, mz_value, intensity, scan_id, input ready);
  modport sink   (input valid, action, slot, mz_value, intensity, scan_id, output ready);
endinterface

interface mwic_res_if;
  logic                              valid;
  logic                              ready;
  logic [mwic_pkg::SLOT_FIELD_W-1:0] hit_slot;
  logic [mwic_pkg::SCAN_W-1:0]       result_scan;
  logic [mwic_pkg::BASE_W-1:0]       base_peak;
  logic [mwic_pkg::SUM_W-1:0]        ion_total;
  logic                              last;

  modport source (output valid, hit_slot, result_scan, base_peak, ion_total, last,
                  input ready);
  modport sink   (input valid, hit_slot, result_scan, base_peak, ion_total, last,
                  output ready);
endinterface

interface mwic_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mwic_pkg::CFG_IDX_W-1:0]  index;
  logic [mwic_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/mwic_fifo.sv @@
// ----------------------------------------------------------------------------
// Mass window ion chromatogram: request queue
// Small valid/ready FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module mwic_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = mwic_pkg::QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  T     push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output T     pop_data_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

@@ sv/mwic_front.sv @@
// ----------------------------------------------------------------------------
// Mass window ion chromatogram: front end
// Accepts requests, drops the ones without effect, and turns a load into
// window bounds (multiply, then a four-step reciprocal multiply for the
// division by the ppm scale).
// ----------------------------------------------------------------------------
module mwic_front #(
  parameter int SLOTS          = mwic_pkg::SLOTS_DEFAULT,
  parameter int INTENSITY_BITS = mwic_pkg::INTENSITY_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mwic_req_if.sink                     req_i,
  input  logic [mwic_pkg::PPM_W-1:0]   ppm_i,
  output mwic_pkg::mwic_op_t           op_o,
  output logic                         op_valid_o,
  input  logic                         op_ready_i
);
  import mwic_pkg::*;

  localparam int IW_EFF = (INTENSITY_BITS < INT_W) ? INTENSITY_BITS : INT_W;
  localparam logic [INT_W-1:0] INT_MASK = INT_W'((65'd1 << IW_EFF) - 65'd1);
  localparam int PART_W = HALF_W + RLO_W;

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_MUL  = 2'd1;
  localparam logic [1:0] FS_DIV  = 2'd2;
  localparam logic [1:0] FS_PUSH = 2'd3;

  logic [1:0]              st_q, st_d;
  logic [MZ_W-1:0]         mz_q;
  logic [SLOT_FIELD_W-1:0] slot_q;
  logic [QN_W-1:0]         num_q;   // product with the power-of-two part removed
  logic [ACC_W-1:0]        acc_q;
  logic [STEP_W-1:0]       step_q;

  logic              accept, direct_push, load_take;
  logic [INT_W-1:0]  inten_m;
  logic [WIN_W-1:0]  mz_w, tol_w;
  logic [PROD_W-1:0] prod;
  logic [HALF_W-1:0] mul_a;
  logic [RLO_W-1:0]  mul_b;
  logic [PART_W-1:0] part;
  logic [ACC_W-1:0]  part_sh;

  assign req_i.ready = (st_q == FS_IDLE) && op_ready_i;
  assign accept      = req_i.valid && req_i.ready;
  assign inten_m     = req_i.intensity & INT_MASK;
  assign mz_w        = WIN_W'(mz_q);
  assign tol_w       = WIN_W'(acc_q[ACC_W-1:RECIP_SHIFT]);

  // partial product per step: low/high half of the numerator times
  // low/high part of the reciprocal
  assign prod  = PROD_W'(mz_q) * PROD_W'(ppm_i);
  assign mul_a = step_q[1] ? num_q[QN_W-1:HALF_W] : num_q[HALF_W-1:0];
  assign mul_b = step_q[0] ? RECIP_HI : RECIP_LO;
  assign part  = PART_W'(mul_a) * PART_W'(mul_b);

  always_comb begin
    case (step_q)
      2'd0:    part_sh = ACC_W'(part);
      2'd1:    part_sh = ACC_W'(part) << RLO_W;
      2'd2:    part_sh = ACC_W'(part) << HALF_W;
      default: part_sh = ACC_W'(part) << (HALF_W + RLO_W);
    endcase
  end

  always_comb begin
    direct_push = 1'b0;
    load_take   = 1'b0;
    case (req_i.action)
      ACT_LOAD: load_take   = accept && (int'(req_i.slot) < SLOTS);
      ACT_PEAK: direct_push = accept && (inten_m != '0);
      ACT_SCAN: direct_push = accept;
      default:  ;
    endcase
  end

  always_comb begin
    op_valid_o = direct_push || (st_q == FS_PUSH);
    if (st_q == FS_PUSH) begin
      op_o.kind      = KIND_LOAD;
      op_o.slot      = slot_q;
      op_o.lo        = (tol_w > mz_w) ? '0 : mz_w - tol_w;
      op_o.hi        = mz_w + tol_w;
      op_o.intensity = '0;
      op_o.scan      = '0;
    end else begin
      op_o.kind      = (req_i.action == ACT_SCAN) ? KIND_SCAN : KIND_PEAK;
      op_o.slot      = req_i.slot;
      op_o.lo        = WIN_W'(req_i.mz_value);
      op_o.hi        = '0;
      op_o.intensity = inten_m;
      op_o.scan      = req_i.scan_id;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      FS_IDLE: if (load_take) st_d = FS_MUL;
      FS_MUL:  st_d = FS_DIV;
      FS_DIV:  if (step_q == STEP_W'(DIV_STEPS - 1)) st_d = FS_PUSH;
      FS_PUSH: if (op_ready_i) st_d = FS_IDLE;
      default: st_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // datapath: product, then one partial product accumulated per cycle
  always_ff @(posedge clk_i) begin
    if (load_take) begin
      mz_q   <= req_i.mz_value;
      slot_q <= req_i.slot;
    end
    if (st_q == FS_MUL) begin
      num_q  <= prod[PROD_W-1:SCALE_SHIFT];
      acc_q  <= '0;
      step_q <= '0;
    end else if (st_q == FS_DIV) begin
      acc_q  <= acc_q + part_sh;
      step_q <= step_q + 1'b1;
    end
  end
endmodule

@@ sv/mwic_back.sv @@
// ----------------------------------------------------------------------------
// Mass window ion chromatogram: back end
// Per-slot windows and accumulators, parallel peak update, and a drain
// that shifts the accumulators out slot by slot at end of scan.
// ----------------------------------------------------------------------------
module mwic_back #(
  parameter int SLOTS = mwic_pkg::SLOTS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mwic_pkg::mwic_op_t           op_i,
  input  logic                         op_valid_i,
  output logic                         op_ready_o,
  input  logic [mwic_pkg::COUNT_W-1:0] count_i,
  mwic_res_if.source                   res_o
);
  import mwic_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] st_q;

  logic [WIN_W-1:0]  win_lo_q [SLOTS];
  logic [WIN_W-1:0]  win_hi_q [SLOTS];
  logic [BASE_W-1:0] max_q [SLOTS], max_d [SLOTS];
  logic [SUM_W-1:0]  sum_q [SLOTS], sum_d [SLOTS];
  logic [SUM_W:0]    sum_add [SLOTS];
  logic [SLOTS-1:0]  hit_q, hit_d, in_win;

  logic [IDX_W-1:0]     idx_q;
  logic [OUT_CNT_W-1:0] take_cnt_q;
  logic [SCAN_W-1:0]    scan_q;

  logic                    pend_v_q;
  logic [SLOT_FIELD_W-1:0] pend_slot_q;
  logic [BASE_W-1:0]       pend_max_q;
  logic [SUM_W-1:0]        pend_sum_q;

  logic                    res_valid_q, res_last_q;
  logic [SLOT_FIELD_W-1:0] res_slot_q;
  logic [SCAN_W-1:0]       res_scan_q;
  logic [BASE_W-1:0]       res_max_q;
  logic [SUM_W-1:0]        res_sum_q;

  logic op_fire, peak_fire, load_fire, scan_fire;
  logic out_free, take, stall, shift, load_out, res_last_d;

  assign op_ready_o = (st_q == ST_RUN);
  assign op_fire    = op_valid_i && op_ready_o;
  assign peak_fire  = op_fire && (op_i.kind == KIND_PEAK);
  assign load_fire  = op_fire && (op_i.kind == KIND_LOAD);
  assign scan_fire  = op_fire && (op_i.kind == KIND_SCAN);

  assign out_free   = !res_valid_q || res_o.ready;
  assign take       = hit_q[0] && (take_cnt_q < OUT_CNT_W'(MAX_OUT));
  assign stall      = take && pend_v_q && !out_free;
  assign shift      = (st_q == ST_DRAIN) && !stall;
  // a result leaves the pending slot once the next hit shows up, or at the end
  assign load_out   = (shift && take && pend_v_q)
                   || ((st_q == ST_FLUSH) && pend_v_q && out_free);
  assign res_last_d = (st_q == ST_FLUSH);

  // lanes: window compare and accumulator update
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      in_win[s]  = (s < int'(count_i)) && (win_lo_q[s] <= op_i.lo)
                && (op_i.lo <= win_hi_q[s]);
      sum_add[s] = {1'b0, sum_q[s]} + (SUM_W + 1)'(op_i.intensity);
    end
    hit_d = hit_q;
    for (int s = 0; s < SLOTS; s++) begin
      max_d[s] = max_q[s];
      sum_d[s] = sum_q[s];
    end
    if (shift) begin
      hit_d = hit_q >> 1;
      for (int s = 0; s < SLOTS - 1; s++) begin
        max_d[s] = max_q[s + 1];
        sum_d[s] = sum_q[s + 1];
      end
      max_d[SLOTS-1] = '0;
      sum_d[SLOTS-1] = '0;
    end else if (peak_fire) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (in_win[s]) begin
          hit_d[s] = 1'b1;
          if (op_i.intensity > max_q[s]) begin
            max_d[s] = op_i.intensity;
          end
          sum_d[s] = sum_add[s][SUM_W] ? '1 : sum_add[s][SUM_W-1:0];
        end
      end
    end
  end

  // windows: undefined until loaded
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (load_fire && (int'(op_i.slot) == s)) begin
        win_lo_q[s] <= op_i.lo;
        win_hi_q[s] <= op_i.hi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        max_q[s] <= '0;
        sum_q[s] <= '0;
      end
    end else begin
      hit_q <= hit_d;
      for (int s = 0; s < SLOTS; s++) begin
        max_q[s] <= max_d[s];
        sum_q[s] <= sum_d[s];
      end
    end
  end

  // drain control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_RUN;
      idx_q       <= '0;
      take_cnt_q  <= '0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      case (st_q)
        ST_RUN: begin
          if (scan_fire) begin
            idx_q      <= '0;
            take_cnt_q <= '0;
            pend_v_q   <= 1'b0;
            st_q       <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (shift) begin
            if (take) begin
              pend_v_q   <= 1'b1;
              take_cnt_q <= take_cnt_q + 1'b1;
            end
            if (idx_q == IDX_W'(SLOTS - 1)) begin
              st_q <= ST_FLUSH;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q || out_free) begin
            pend_v_q <= 1'b0;
            st_q     <= ST_RUN;
          end
        end
        default: st_q <= ST_RUN;
      endcase
      if (load_out) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_fire) begin
      scan_q <= op_i.scan;
    end
    if (shift && take) begin
      pend_slot_q <= SLOT_FIELD_W'(idx_q);
      pend_max_q  <= max_q[0];
      pend_sum_q  <= sum_q[0];
    end
    if (load_out) begin
      res_slot_q <= pend_slot_q;
      res_scan_q <= scan_q;
      res_max_q  <= pend_max_q;
      res_sum_q  <= pend_sum_q;
      res_last_q <= res_last_d;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.hit_slot    = res_slot_q;
  assign res_o.result_scan = res_scan_q;
  assign res_o.base_peak   = res_max_q;
  assign res_o.ion_total   = res_sum_q;
  assign res_o.last        = res_last_q;

`include "mass_window_ion_chromatogram_macros.svh"

  `MWIC_ASSERT(a_flush_clear, st_q == ST_FLUSH, hit_q == '0, "accumulators not cleared")
  `MWIC_ASSERT(a_take_bound, st_q == ST_DRAIN, take_cnt_q <= OUT_CNT_W'(MAX_OUT), "too many")
  `MWIC_ASSERT(a_no_overwrite, load_out, out_free, "result overwritten while waiting")
  `MWIC_ASSERT_NXT(a_drain_start, scan_fire, !pend_v_q && take_cnt_q == '0, "bad drain start")
endmodule

@@ sv/mass_window_ion_chromatogram.sv @@
// ----------------------------------------------------------------------------
// Mass window ion chromatogram: top level
// Extracted ion chromatogram over ppm windows around up to SLOTS precursors.
// ----------------------------------------------------------------------------
// Loads set slot windows to centre +/- floor(centre * ppm_tolerance / 1e8)
// (m/z in 1e-5 units, tolerance in 0.01 ppm); peaks with a nonzero intensity
// update the max and saturating sum of every in-use window holding them; end
// of scan emits one result per hit slot in ascending order, the final one
// flagged last, and clears the accumulators. Rate: peak and end-of-scan
// requests are taken one per cycle while no load is in progress and the
// four-entry queue has room; the back end retires a peak per cycle while
// not draining. A load holds the request port from accept through the
// 29x17 multiply and the reciprocal divide by the ppm scale (four 19x20
// partial products, one per step) to queueing; a full queue extends
// that. An end of scan holds the back end while the accumulators shift out
// one slot per cycle past a pending and an output register; result
// back-pressure stalls the shift. Window bounds are undefined until a slot
// is loaded; there is no clearing pass after reset. Configuration writes
// are accepted every cycle and must come while idle.
module mass_window_ion_chromatogram #(
  parameter int SLOTS          = mwic_pkg::SLOTS_DEFAULT,
  parameter int INTENSITY_BITS = mwic_pkg::INTENSITY_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mwic_req_if.sink   req_i,
  mwic_res_if.source res_o,
  mwic_cfg_if.sink   cfg_i
);
  import mwic_pkg::*;

  logic [PPM_W-1:0]   ppm_q;    // half window, 0.01 ppm
  logic [COUNT_W-1:0] count_q;  // slots in use

  mwic_op_t fr_op, bk_op;
  logic     fr_valid, fr_ready, bk_valid, bk_ready;

  // config registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_q   <= PPM_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_PPM_TOLERANCE:   ppm_q   <= cfg_i.data[PPM_W-1:0];
        CFG_PRECURSOR_COUNT: count_q <= cfg_i.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: classify, compute window bounds for loads
  mwic_front #(
    .SLOTS          (SLOTS),
    .INTENSITY_BITS (INTENSITY_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .ppm_i      (ppm_q),
    .op_o       (fr_op),
    .op_valid_o (fr_valid),
    .op_ready_i (fr_ready)
  );

  // queue lets front keep taking peaks while the back end drains
  mwic_fifo #(
    .T     (mwic_op_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (fr_op),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .pop_data_o   (bk_op),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready)
  );

  // back: windows, accumulators, result drain
  mwic_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (bk_op),
    .op_valid_i (bk_valid),
    .op_ready_o (bk_ready),
    .count_i    (count_q),
    .res_o      (res_o)
  );
endmodule
